// ===== rtl/kmd_pkg.sv =====
package kmd_pkg;

	localparam int MATRIX_SIDE_DEF  = 3;
	localparam int BUTTON_COUNT_DEF = 10;

	localparam int MAX_RESULTS = 5;
	localparam int TIME_W      = 32;
	localparam int KEY_W       = 3;
	localparam int DEB_W       = 10;
	localparam int ID_W        = 4;
	localparam int COL_W       = 2;
	localparam int CNT_W       = 3;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_HW_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd1;

	localparam logic MODE_DIRECT = 1'b0;
	localparam logic MODE_MATRIX = 1'b1;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 10'd50;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [KEY_W-1:0]  key_levels;
		logic              clear_level;
		logic              click_level;
	} poll_t;

	typedef struct packed {
		logic             has_event;
		logic [ID_W-1:0]  button_id;
		logic             pressed;
		logic [COL_W-1:0] next_col;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            pressed;
	} ev_t;

	typedef struct packed {
		logic hit_a;
		logic lvl_a;
		logic hit_b;
		logic lvl_b;
	} cell_req_t;

	typedef struct packed {
		logic evt_a;
		logic evt_b;
	} cell_rsp_t;

endpackage

// ===== rtl/kmd_cell.sv =====
module kmd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [kmd_pkg::TIME_W-1:0]    now_ms,
	input  logic [kmd_pkg::DEB_W-1:0]     debounce_ms,
	input  kmd_pkg::cell_req_t            req,
	input  logic                          commit,
	output kmd_pkg::cell_rsp_t            rsp
);

	logic                       raw_q;
	logic                       acc_q;
	logic [kmd_pkg::TIME_W-1:0] ct_q;

	logic                       raw_a, acc_a, fire_a;
	logic [kmd_pkg::TIME_W-1:0] ct_a;
	logic                       raw_b, acc_b, fire_b;
	logic [kmd_pkg::TIME_W-1:0] ct_b;
	logic [kmd_pkg::TIME_W-1:0] deb_ext;

	assign deb_ext = kmd_pkg::TIME_W'(debounce_ms);

	// Up to two updates per poll: a row or clear-button sample, then the click sample when
	// the click button shares this debouncer.
	always_comb begin
		raw_a  = raw_q;
		acc_a  = acc_q;
		ct_a   = ct_q;
		fire_a = 1'b0;
		if (req.hit_a) begin
			if (req.lvl_a != raw_q) begin
				ct_a = now_ms;
			end
			fire_a = ((now_ms - ct_a) > deb_ext) && (req.lvl_a != acc_q);
			if (fire_a) begin
				acc_a = req.lvl_a;
			end
			raw_a = req.lvl_a;
		end
		raw_b  = raw_a;
		acc_b  = acc_a;
		ct_b   = ct_a;
		fire_b = 1'b0;
		if (req.hit_b) begin
			if (req.lvl_b != raw_a) begin
				ct_b = now_ms;
			end
			fire_b = ((now_ms - ct_b) > deb_ext) && (req.lvl_b != acc_a);
			if (fire_b) begin
				acc_b = req.lvl_b;
			end
			raw_b = req.lvl_b;
		end
	end

	assign rsp.evt_a = fire_a;
	assign rsp.evt_b = fire_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= 1'b0;
			acc_q <= 1'b0;
			ct_q  <= '0;
		end else if (commit) begin
			raw_q <= raw_b;
			acc_q <= acc_b;
			ct_q  <= ct_b;
		end
	end

endmodule

// ===== rtl/kmd_result_buf.sv =====
module kmd_result_buf (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  kmd_pkg::ev_t [kmd_pkg::MAX_RESULTS-1:0] ev_list,
	input  logic [kmd_pkg::CNT_W-1:0]               ev_cnt,
	input  logic [kmd_pkg::COL_W-1:0]               next_col,
	output logic                                    valid,
	input  logic                                    ready,
	output kmd_pkg::result_t                        result
);

	kmd_pkg::ev_t [kmd_pkg::MAX_RESULTS-1:0] ev_s2;
	logic [kmd_pkg::CNT_W-1:0]               cnt_s2;
	logic [kmd_pkg::COL_W-1:0]               col_s2;
	logic                                    valid_q;
	logic [kmd_pkg::CNT_W-1:0]               idx_q;
	logic                                    is_last;

	assign is_last = (cnt_s2 == '0) || (idx_q == cnt_s2 - kmd_pkg::CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && ready) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + kmd_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_s2  <= ev_list;
			cnt_s2 <= ev_cnt;
			col_s2 <= next_col;
		end
	end

	assign valid            = valid_q;
	assign result.has_event = (cnt_s2 != '0);
	assign result.button_id = (cnt_s2 != '0) ? ev_s2[idx_q].id : '0;
	assign result.pressed   = (cnt_s2 != '0) ? ev_s2[idx_q].pressed : 1'b0;
	assign result.next_col  = col_s2;
	assign result.last      = is_last;

endmodule

// ===== rtl/key_matrix_debouncer_top.sv =====
// Channel  | Signals                                  | Transfers
// poll     | poll_valid, poll_ready, poll             | one sample of the pins per item
// result   | result_valid, result_ready, result       | one event or status item
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| one register write, always ready
//
// A poll is held in the input register until the result buffer can take it, then all
// debouncers update at once and its one to five results load the result buffer.
// The first result is offered from the result buffer, which loads from the input register;
// the buffer then gives one result per cycle while result_ready is high, so a poll
// occupies the output until its last result is accepted.
// A new poll is taken while the buffer still drains; a stalled output holds both stages.
// Reset clears all debouncers, sets the scan column to one and loads the register defaults.
module key_matrix_debouncer_top #(
	parameter int MATRIX_SIDE  = kmd_pkg::MATRIX_SIDE_DEF,
	parameter int BUTTON_COUNT = kmd_pkg::BUTTON_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            poll_valid,
	output logic                            poll_ready,
	input  kmd_pkg::poll_t                  poll,
	output logic                            result_valid,
	input  logic                            result_ready,
	output kmd_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kmd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kmd_pkg::DEB_W-1:0]       cfg_data
);

	localparam int MID_W = $clog2(((MATRIX_SIDE * MATRIX_SIDE > BUTTON_COUNT) ?
		MATRIX_SIDE * MATRIX_SIDE : BUTTON_COUNT) + 1);
	localparam logic [MID_W-1:0] CLEAR_ID = MID_W'(BUTTON_COUNT - 2);
	localparam logic [MID_W-1:0] CLICK_ID = MID_W'(BUTTON_COUNT - 1);
	localparam int NSLOT = kmd_pkg::MAX_RESULTS;

	logic                        hw_mode_q;
	logic [kmd_pkg::DEB_W-1:0]   debounce_q;
	logic [kmd_pkg::COL_W-1:0]   scan_q;

	kmd_pkg::poll_t              poll_s1;
	logic                        valid_s1;
	logic                        s2_load;

	logic [kmd_pkg::KEY_W-1:0]   key_pressed;
	logic [NSLOT-1:0]            row_pressed;
	logic [NSLOT-1:0]            slot_use;
	logic [NSLOT-1:0]            slot_click;
	logic [NSLOT-1:0]            slot_lvl;
	logic [NSLOT-1:0]            slot_evt;
	logic [MID_W-1:0]            slot_id [NSLOT];

	kmd_pkg::cell_req_t          req [BUTTON_COUNT];
	kmd_pkg::cell_rsp_t          rsp [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0]     evt_a_vec;

	kmd_pkg::ev_t [NSLOT-1:0]    ev_list;
	logic [kmd_pkg::CNT_W-1:0]   ev_cnt;
	logic [kmd_pkg::COL_W-1:0]   next_col;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_mode_q  <= kmd_pkg::MODE_MATRIX;
			debounce_q <= kmd_pkg::DEBOUNCE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				kmd_pkg::REG_HW_MODE: begin
					hw_mode_q <= cfg_data[0];
				end
				kmd_pkg::REG_DEBOUNCE: begin
					debounce_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign s2_load    = valid_s1 && (!result_valid || (result_ready && result.last));
	assign poll_ready = !valid_s1 || s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_valid && poll_ready) begin
			valid_s1 <= 1'b1;
		end else if (s2_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && poll_ready) begin
			poll_s1 <= poll;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= kmd_pkg::COL_W'(1 % MATRIX_SIDE);
		end else if (s2_load) begin
			scan_q <= next_col;
		end
	end

	assign key_pressed = ~poll_s1.key_levels;
	assign row_pressed = NSLOT'(key_pressed);

	always_comb begin
		for (int k = 0; k < NSLOT; k++) begin
			slot_use[k]   = 1'b0;
			slot_click[k] = 1'b0;
			slot_lvl[k]   = 1'b0;
			slot_id[k]    = '0;
			if (hw_mode_q == kmd_pkg::MODE_DIRECT) begin
				if (k < kmd_pkg::KEY_W) begin
					slot_use[k] = 1'b1;
					slot_id[k]  = MID_W'(k);
					slot_lvl[k] = row_pressed[k];
				end else if (k == NSLOT - 2) begin
					slot_use[k] = 1'b1;
					slot_id[k]  = CLEAR_ID;
					slot_lvl[k] = !poll_s1.clear_level;
				end else if (k == NSLOT - 1) begin
					slot_use[k]   = 1'b1;
					slot_click[k] = 1'b1;
					slot_id[k]    = CLICK_ID;
					slot_lvl[k]   = !poll_s1.click_level;
				end
			end else begin
				if (k < MATRIX_SIDE) begin
					slot_id[k]  = MID_W'(scan_q) * MID_W'(MATRIX_SIDE) + MID_W'(k);
					slot_use[k] = (slot_id[k] < MID_W'(BUTTON_COUNT));
					slot_lvl[k] = row_pressed[k];
				end else if (k == MATRIX_SIDE) begin
					slot_use[k]   = 1'b1;
					slot_click[k] = 1'b1;
					slot_id[k]    = CLICK_ID;
					slot_lvl[k]   = !poll_s1.click_level;
				end
			end
		end
	end

	for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_cell
		logic hit;
		logic lvl;

		always_comb begin
			hit = 1'b0;
			lvl = 1'b0;
			for (int k = 0; k < NSLOT; k++) begin
				if (slot_use[k] && !slot_click[k] && (slot_id[k] == MID_W'(i))) begin
					hit = 1'b1;
					lvl = slot_lvl[k];
				end
			end
		end

		assign req[i].hit_a = hit;
		assign req[i].lvl_a = lvl;
		assign req[i].hit_b = (i == BUTTON_COUNT - 1);
		assign req[i].lvl_b = !poll_s1.click_level;
		assign evt_a_vec[i] = rsp[i].evt_a;

		kmd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.now_ms      (poll_s1.now_ms),
			.debounce_ms (debounce_q),
			.req         (req[i]),
			.commit      (s2_load),
			.rsp         (rsp[i])
		);
	end

	always_comb begin
		for (int k = 0; k < NSLOT; k++) begin
			slot_evt[k] = 1'b0;
			if (slot_use[k]) begin
				if (slot_click[k]) begin
					slot_evt[k] = rsp[BUTTON_COUNT-1].evt_b;
				end else begin
					for (int i = 0; i < BUTTON_COUNT; i++) begin
						if (slot_id[k] == MID_W'(i)) begin
							slot_evt[k] = evt_a_vec[i];
						end
					end
				end
			end
		end
	end

	always_comb begin
		ev_cnt  = '0;
		ev_list = '0;
		for (int k = 0; k < NSLOT; k++) begin
			if (slot_evt[k]) begin
				ev_list[ev_cnt].id      = slot_id[k][kmd_pkg::ID_W-1:0];
				ev_list[ev_cnt].pressed = slot_lvl[k];
				ev_cnt = ev_cnt + kmd_pkg::CNT_W'(1);
			end
		end
	end

	always_comb begin
		if (hw_mode_q == kmd_pkg::MODE_MATRIX) begin
			if (scan_q == kmd_pkg::COL_W'(MATRIX_SIDE - 1)) begin
				next_col = '0;
			end else begin
				next_col = scan_q + kmd_pkg::COL_W'(1);
			end
		end else begin
			next_col = scan_q;
		end
	end

	kmd_result_buf u_result_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s2_load),
		.ev_list  (ev_list),
		.ev_cnt   (ev_cnt),
		.next_col (next_col),
		.valid    (result_valid),
		.ready    (result_ready),
		.result   (result)
	);

	a_poll_lands: assert property (@(posedge clk) disable iff (!arst_n)
		poll_valid && poll_ready |=> valid_s1)
		else $error("accepted poll did not reach the input register");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result.last && !valid_s1 |=> !result_valid)
		else $error("result buffer did not empty after its final item");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_event |-> result.last)
		else $error("status item is not the final item of its poll");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= kmd_pkg::COL_W'(MATRIX_SIDE - 1))
		else $error("scan column out of range");

endmodule

// ===== dv/key_matrix_debouncer_checker.sv =====
`timescale 1ns / 1ps

module key_matrix_debouncer_checker
	import kmd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 poll_valid,
	input  logic                 poll_ready,
	input  poll_t                poll,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DEB_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	localparam int SIDE     = MATRIX_SIDE_DEF;
	localparam int BUTTONS  = BUTTON_COUNT_DEF;
	localparam int CLEAR_ID = BUTTONS - 2;
	localparam int CLICK_ID = BUTTONS - 1;

	logic              mode;
	logic [DEB_W-1:0]  delay_ms;
	logic              raw_lvl [BUTTONS];
	logic              acc_lvl [BUTTONS];
	logic [TIME_W-1:0] changed_at [BUTTONS];
	int                scan_col;
	result_t           fresh[$];
	result_t           due_results[$];

	function automatic void settle_button(input logic [TIME_W-1:0] now, input logic lvl,
			input int id);
		result_t ev;
		if (id >= BUTTONS) begin
			return;
		end
		if (lvl != raw_lvl[id]) begin
			changed_at[id] = now;
		end
		if (TIME_W'(now - changed_at[id]) > TIME_W'(delay_ms) && lvl != acc_lvl[id]) begin
			acc_lvl[id] = lvl;
			if (fresh.size() < MAX_RESULTS) begin
				ev = '0;
				ev.has_event = 1'b1;
				ev.button_id = ID_W'(id);
				ev.pressed = lvl;
				fresh.push_back(ev);
			end
		end
		raw_lvl[id] = lvl;
	endfunction

	task automatic scan_poll(input poll_t p);
		int col;
		result_t item;
		fresh.delete();
		if (mode == MODE_DIRECT) begin
			for (int r = 0; r < KEY_W; r++) begin
				settle_button(p.now_ms, !p.key_levels[r], r);
			end
			settle_button(p.now_ms, !p.clear_level, CLEAR_ID);
			settle_button(p.now_ms, !p.click_level, CLICK_ID);
		end else begin
			col = scan_col % SIDE;
			for (int r = 0; r < SIDE; r++) begin
				settle_button(p.now_ms, (r < KEY_W) ? !p.key_levels[r] : 1'b0, col * SIDE + r);
			end
			settle_button(p.now_ms, !p.click_level, CLICK_ID);
			scan_col = (col + 1) % SIDE;
		end
		if (fresh.size() == 0) begin
			fresh.push_back('0);
		end
		for (int k = 0; k < fresh.size(); k++) begin
			item = fresh[k];
			item.next_col = COL_W'(scan_col);
			item.last = (k == fresh.size() - 1);
			due_results.push_back(item);
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			mode = MODE_MATRIX;
			delay_ms = DEBOUNCE_RESET;
			for (int i = 0; i < BUTTONS; i++) begin
				raw_lvl[i] = 1'b0;
				acc_lvl[i] = 1'b0;
				changed_at[i] = '0;
			end
			scan_col = 1 % SIDE;
			due_results.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: has_event %0d button_id %0d pressed %0d",
						result.has_event, result.button_id, result.pressed);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("has_event", want.has_event, result.has_event);
					check_field("button_id", want.button_id, result.button_id);
					check_field("pressed", want.pressed, result.pressed);
					check_field("next_col", want.next_col, result.next_col);
					check_field("last", want.last, result.last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HW_MODE: begin
						mode = cfg_data[0];
					end
					REG_DEBOUNCE: begin
						delay_ms = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (poll_valid && poll_ready) begin
				scan_poll(poll);
			end
		end
		pending = due_results.size();
	end

endmodule

// ===== dv/key_matrix_debouncer_top_tb.sv =====
`timescale 1ns / 1ps

module key_matrix_debouncer_top_tb;
	import kmd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SIDE        = MATRIX_SIDE_DEF;
	localparam int CLEAR_BTN   = BUTTON_COUNT_DEF - 2;
	localparam int CLICK_BTN   = BUTTON_COUNT_DEF - 1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 poll_valid = 1'b0;
	logic                 poll_ready;
	poll_t                poll = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DEB_W-1:0]     cfg_data = '0;

	int fail_count;
	int pending;
	int cycles = 0;

	int                   send_idle_pct = 0;
	int                   stall_pct = 0;
	logic                 mode_now = MODE_MATRIX;
	int                   scan_col = 1 % SIDE;
	int                   deb = 50;
	logic [TIME_W-1:0]    clock_ms;
	logic [CLICK_BTN:0]   held = '0;

	key_matrix_debouncer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.poll_valid(poll_valid),
		.poll_ready(poll_ready),
		.poll(poll),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	key_matrix_debouncer_checker kmd_check (
		.clk(clk),
		.arst_n(arst_n),
		.poll_valid(poll_valid),
		.poll_ready(poll_ready),
		.poll(poll),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_poll(input poll_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			poll_valid = 1'b0;
			@(negedge clk);
		end
		poll_valid = 1'b1;
		poll = p;
		do @(posedge clk); while (!poll_ready);
		@(negedge clk);
		if (mode_now == MODE_MATRIX) begin
			scan_col = (scan_col + 1) % SIDE;
		end
	endtask

	task automatic wait_drained();
		poll_valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DEB_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == REG_HW_MODE) begin
			mode_now = value[0];
		end else begin
			deb = value;
		end
	endtask

	function automatic poll_t pins(input logic [TIME_W-1:0] t, input logic [KEY_W-1:0] keys,
			input logic clr, input logic clk_pin);
		poll_t p;
		p.now_ms = t;
		p.key_levels = keys;
		p.clear_level = clr;
		p.click_level = clk_pin;
		return p;
	endfunction

	function automatic poll_t build_poll();
		poll_t p;
		int bit_pos;
		p.now_ms = clock_ms;
		if (mode_now == MODE_DIRECT) begin
			p.key_levels = ~held[KEY_W-1:0];
			p.clear_level = ~held[CLEAR_BTN];
		end else begin
			for (int r = 0; r < KEY_W; r++) begin
				p.key_levels[r] = ~held[scan_col * SIDE + r];
			end
			p.clear_level = 1'($urandom);
		end
		p.click_level = ~held[CLICK_BTN];
		if ($urandom_range(0, 99) < 15) begin
			bit_pos = $urandom_range(0, KEY_W + 1);
			p[bit_pos] = ~p[bit_pos];
		end
		return p;
	endfunction

	function automatic logic [TIME_W-1:0] step_ms();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return $urandom_range(0, deb / 3 + 1);
		end else if (roll < 93) begin
			return $urandom_range(deb, deb + 2);
		end else begin
			return $urandom();
		end
	endfunction

	task automatic run_phase(input logic m, input int d, input int n, input int idle,
			input int stall, input bit hold_mid);
		int pick;
		wait_drained();
		write_reg(REG_HW_MODE, {9'($urandom), m});
		write_reg(REG_DEBOUNCE, DEB_W'(d));
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2) begin
				wait_drained();
			end
			clock_ms += step_ms();
			if ($urandom_range(0, 99) < 35) begin
				if (mode_now == MODE_DIRECT) begin
					pick = $urandom_range(0, KEY_W + 1);
					if (pick == KEY_W) begin
						pick = CLEAR_BTN;
					end else if (pick == KEY_W + 1) begin
						pick = CLICK_BTN;
					end
				end else begin
					pick = $urandom_range(0, CLICK_BTN);
				end
				held[pick] = ~held[pick];
			end
			push_poll(build_poll());
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset defaults: matrix mode, column one, 50 ms.
		push_poll(pins(32'h0000_0000, 3'b111, 1'b1, 1'b1));
		push_poll(pins(32'hFFFF_FFFF, 3'b000, 1'b0, 1'b0));

		wait_drained();
		write_reg(REG_HW_MODE, {9'h1FF, MODE_DIRECT});
		write_reg(REG_DEBOUNCE, 10'd0);
		push_poll(pins(32'd100, 3'b000, 1'b0, 1'b0));
		push_poll(pins(32'd101, 3'b000, 1'b0, 1'b0));
		push_poll(pins(32'd102, 3'b111, 1'b1, 1'b1));
		push_poll(pins(32'd103, 3'b111, 1'b1, 1'b1));

		// A delay equal to the elapsed time is not enough; the count wraps at 2^32.
		wait_drained();
		write_reg(REG_DEBOUNCE, 10'd7);
		push_poll(pins(32'hFFFF_FFFC, 3'b110, 1'b1, 1'b1));
		push_poll(pins(32'h0000_0003, 3'b110, 1'b1, 1'b1));
		push_poll(pins(32'h0000_0004, 3'b110, 1'b1, 1'b1));
		push_poll(pins(32'h0000_000C, 3'b111, 1'b1, 1'b1));

		// Two full scans pressed, then two released; row 2 of column 2 is the clear button.
		wait_drained();
		write_reg(REG_HW_MODE, {9'h0AA, MODE_MATRIX});
		write_reg(REG_DEBOUNCE, 10'd0);
		for (int i = 0; i < 2 * SIDE; i++) begin
			push_poll(pins(32'd200 + i, 3'b000, 1'b1, 1'b0));
		end
		for (int i = 0; i < 2 * SIDE; i++) begin
			push_poll(pins(32'd300 + i, 3'b111, 1'b0, 1'b1));
		end

		// The debouncer state survives the change of mode.
		wait_drained();
		write_reg(REG_HW_MODE, {9'h000, MODE_DIRECT});
		push_poll(pins(32'd400, 3'b111, 1'b0, 1'b1));
		push_poll(pins(32'd401, 3'b111, 1'b0, 1'b1));

		clock_ms = $urandom();
		run_phase(MODE_DIRECT, 1, 50, 0, 0, 1'b0);
		run_phase(MODE_MATRIX, 17, 50, 76, 0, 1'b1);
		run_phase(MODE_DIRECT, 1000, 40, 0, 76, 1'b0);
		run_phase(MODE_MATRIX, 0, 50, 33, 33, 1'b0);
		run_phase(MODE_MATRIX, 7, 35, 0, 0, 1'b0);
		run_phase(MODE_DIRECT, 50, 35, 33, 33, 1'b0);

		wait_drained();
		stall_pct = 0;
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
